FILE: rtl/sine_tone_sample_formatter_unit_macros.svh
// ----------------------------------------------------------------------------
// Sine tone sample formatter assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SINE_TONE_SAMPLE_FORMATTER_UNIT_MACROS_SVH
`define SINE_TONE_SAMPLE_FORMATTER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define STS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/sts_pkg.sv
// ----------------------------------------------------------------------------
// Sine tone sample formatter package
// Shared types, register and format codes, and the sine table generator.
// ----------------------------------------------------------------------------
`default_nettype none

package sts_pkg;

	localparam int DEF_NUM_CHANNELS    = 2;
	localparam int DEF_SINE_TABLE_BITS = 10;
	localparam int QUEUE_DEPTH         = 2;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;

	localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_INC = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_AMPLITUDE = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_FORMAT    = 2'd2;

	localparam logic [2:0] FMT_INT32  = 3'd0;
	localparam logic [2:0] FMT_INT16  = 3'd1;
	localparam logic [2:0] FMT_FLOAT  = 3'd2;
	localparam logic [2:0] FMT_INT24  = 3'd3;
	localparam logic [2:0] FMT_LEFT16 = 3'd4;
	localparam logic [2:0] FMT_LEFT18 = 3'd5;
	localparam logic [2:0] FMT_LEFT20 = 3'd6;
	localparam logic [2:0] FMT_LEFT24 = 3'd7;

	localparam logic [31:0] RST_PHASE_INC = 32'd39370534;
	localparam logic [14:0] RST_AMPLITUDE = 15'd6554;
	localparam logic [2:0]  RST_FORMAT    = FMT_INT32;

	localparam longint unsigned Q30_ONE     = 64'd1073741824;
	localparam longint unsigned Q30_HALF_PI = 64'd1686629713;

	typedef struct packed {
		logic [31:0] phase_increment;
		logic [14:0] amplitude;
		logic [2:0]  sample_format;
	} cfg_t;

	// Quarter-wave sine in Q1.15 by a truncating Horner series, used at elaboration.
	function automatic logic [15:0] quarter_sine(longint unsigned r, int unsigned qbits);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint unsigned y;
		longint unsigned q;
		x  = (Q30_HALF_PI * r) >> qbits;
		x2 = (x * x) >> 30;
		t  = Q30_ONE;
		t  = Q30_ONE - ((x2 * t) >> 30) / 110;
		t  = Q30_ONE - ((x2 * t) >> 30) / 72;
		t  = Q30_ONE - ((x2 * t) >> 30) / 42;
		t  = Q30_ONE - ((x2 * t) >> 30) / 20;
		t  = Q30_ONE - ((x2 * t) >> 30) / 6;
		y  = (x * t) >> 30;
		q  = (y + 64'd16384) >> 15;
		if (q > 64'd32767)
			q = 64'd32767;
		return q[15:0];
	endfunction

	function automatic logic signed [15:0] sine_entry(int unsigned idx, int unsigned bits);
		int unsigned     qbits;
		int unsigned     quad;
		longint unsigned r;
		logic [15:0]     v;
		qbits = bits - 2;
		quad  = (idx >> qbits) & 3;
		r     = longint'(idx & ((1 << qbits) - 1));
		if ((quad & 1) != 0)
			v = quarter_sine((longint'(1) << qbits) - r, qbits);
		else
			v = quarter_sine(r, qbits);
		return ((quad & 2) != 0) ? -$signed(v) : $signed(v);
	endfunction

	// Shift n in trunc(s * (2^n - 1) / 2^31) for each integer format.
	function automatic logic [4:0] scale_shift(logic [2:0] fmt);
		logic [4:0] n;
		case (fmt) inside
			FMT_INT16, FMT_LEFT16: n = 5'd15;
			FMT_INT24, FMT_LEFT24: n = 5'd23;
			FMT_LEFT18:            n = 5'd17;
			FMT_LEFT20:            n = 5'd19;
			default:               n = 5'd31;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/sts_fifo.sv
// ----------------------------------------------------------------------------
// Sine tone request queue
// Short first-in first-out store between the front and the back part.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_fifo #(
	parameter int WIDTH = 11
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] pop_data,
	output logic                  full,
	output logic                  empty
);
	import sts_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/sts_front.sv
// ----------------------------------------------------------------------------
// Sine tone front part
// Takes frame ticks, advances the phase and queues the table index.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_front #(
	parameter int SINE_TABLE_BITS = 10
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [7:0]                 s_tdata,    // [0] tone_on
	input  wire sts_pkg::cfg_t              cfg,
	input  wire logic                       queue_full,
	output logic                            push,
	output logic      [SINE_TABLE_BITS:0]   push_data   // {tone_on, table index}
);
	import sts_pkg::*;

	logic [31:0] phase_accum_q;

	assign s_tready  = !queue_full;
	assign push      = s_tvalid && s_tready;
	assign push_data = {s_tdata[0], phase_accum_q[31 -: SINE_TABLE_BITS]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_accum_q <= '0;
		end else if (push) begin
			phase_accum_q <= phase_accum_q + cfg.phase_increment;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/sts_back.sv
// ----------------------------------------------------------------------------
// Sine tone back part
// Table lookup, amplitude scaling, sample formatting and per-channel output.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_back #(
	parameter int NUM_CHANNELS    = 2,
	parameter int SINE_TABLE_BITS = 10
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire sts_pkg::cfg_t            cfg,
	input  wire logic                     queue_empty,
	input  wire logic [SINE_TABLE_BITS:0] queue_data,
	output logic                          pop,
	output logic                          m_tvalid,
	input  wire logic                     m_tready,
	output logic      [39:0]              m_tdata,   // [31:0] sample_word, [34:32] byte_count
	output logic                          m_tuser,   // [0] channel
	output logic                          m_tlast
);
	import sts_pkg::*;

	localparam int ROM_DEPTH = 2 ** SINE_TABLE_BITS;
	localparam int CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	logic signed [15:0] rom [ROM_DEPTH];

	for (genvar i = 0; i < ROM_DEPTH; i++) begin : g_rom
		localparam logic signed [15:0] ENTRY = sine_entry(i, SINE_TABLE_BITS);
		assign rom[i] = ENTRY;
	end

	logic               v_s1, v_s2, v_s3, v_s4;
	logic               en_s1, en_s2, en_s3, en_s4;
	logic               tone_s1;
	logic signed [15:0] sn_s1;
	logic signed [31:0] prod_s2;
	logic               sign_s3;
	logic [30:0]        mag_s3;
	logic [30:0]        scaled_s3;
	logic [4:0]         top_s3;
	logic [31:0]        word_s4;
	logic [2:0]         bytes_s4;

	logic               out_valid_q;
	logic [31:0]        word_q;
	logic [2:0]         bytes_q;
	logic [CH_W-1:0]    ch_q;
	logic               last_ch;
	logic               take;
	logic               emit_free;

	assign last_ch   = (ch_q == CH_W'(NUM_CHANNELS - 1));
	assign take      = out_valid_q && m_tready;
	assign emit_free = !out_valid_q || (take && last_ch);

	assign en_s4 = !v_s4 || emit_free;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign pop   = en_s1 && !queue_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1)
				v_s1 <= pop;
			if (en_s2)
				v_s2 <= v_s1;
			if (en_s3)
				v_s3 <= v_s2;
			if (en_s4)
				v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			tone_s1 <= queue_data[SINE_TABLE_BITS];
			sn_s1   <= rom[queue_data[SINE_TABLE_BITS-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2)
			prod_s2 <= tone_s1 ? 32'(sn_s1 * $signed({1'b0, cfg.amplitude}) * 2) : '0;
	end

	logic [30:0] mag;
	logic [62:0] wide;
	logic [4:0]  top;

	always_comb begin
		mag  = prod_s2[31] ? 31'(-prod_s2) : prod_s2[30:0];
		wide = ({32'd0, mag} << scale_shift(cfg.sample_format)) - {32'd0, mag};
		top  = '0;
		for (int i = 0; i < 31; i++) begin
			if (mag[i])
				top = 5'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			sign_s3   <= prod_s2[31];
			mag_s3    <= mag;
			scaled_s3 <= wide[61:31];
			top_s3    <= top;
		end
	end

	logic [31:0] ival;
	logic [4:0]  sh;
	logic [30:0] rem;
	logic [30:0] half;
	logic [24:0] mant;
	logic [7:0]  expo;
	logic [31:0] fword;
	logic [31:0] word;
	logic [2:0]  bytes;

	always_comb begin
		ival = sign_s3 ? -{1'b0, scaled_s3} : {1'b0, scaled_s3};
		sh   = '0;
		rem  = '0;
		half = '0;
		expo = 8'(top_s3) + 8'd96;
		if (top_s3 > 5'd23) begin
			sh   = top_s3 - 5'd23;
			mant = 25'(mag_s3 >> sh);
			rem  = mag_s3 & ((31'd1 << sh) - 31'd1);
			half = 31'd1 << (sh - 5'd1);
			if ((rem > half) || ((rem == half) && mant[0]))
				mant = mant + 25'd1;
			if (mant[24]) begin
				mant = mant >> 1;
				expo = expo + 8'd1;
			end
		end else begin
			mant = 25'(mag_s3 << (5'd23 - top_s3));
		end
		fword = (mag_s3 == '0) ? '0 : {sign_s3, expo, mant[22:0]};
		bytes = 3'd4;
		case (cfg.sample_format)
			FMT_INT16: begin
				word  = {16'd0, ival[15:0]};
				bytes = 3'd2;
			end
			FMT_FLOAT:  word = fword;
			FMT_INT24: begin
				word  = {8'd0, ival[23:0]};
				bytes = 3'd3;
			end
			FMT_LEFT16: word = ival << 16;
			FMT_LEFT18: word = ival << 14;
			FMT_LEFT20: word = ival << 12;
			FMT_LEFT24: word = ival << 8;
			default:    word = ival;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			word_s4  <= word;
			bytes_s4 <= bytes;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_free) begin
			word_q  <= word_s4;
			bytes_q <= bytes_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			ch_q        <= '0;
		end else if (emit_free) begin
			out_valid_q <= v_s4;
			ch_q        <= '0;
		end else if (take) begin
			ch_q <= ch_q + 1'b1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, bytes_q, word_q};
	assign m_tuser  = ch_q[0];
	assign m_tlast  = last_ch;

endmodule

`default_nettype wire

FILE: rtl/sine_tone_sample_formatter_unit.sv
// ----------------------------------------------------------------------------
// Sine tone sample formatter unit
// Phase-accumulator sine tone generator with selectable output sample format.
// ----------------------------------------------------------------------------
// Each accepted frame tick yields NUM_CHANNELS words, one per cycle while
// m_tready is high; the single output register takes the next tick's word
// only when the last channel word of a frame is taken. A tick passes a
// two-entry request queue, four back stages (table read, amplitude multiply,
// magnitude and scaling, formatting) and the output register. The user must
// write configuration only while idle; the block itself does not enforce it.
`default_nettype none

`include "sine_tone_sample_formatter_unit_macros.svh"

module sine_tone_sample_formatter_unit #(
	parameter int NUM_CHANNELS    = sts_pkg::DEF_NUM_CHANNELS,
	parameter int SINE_TABLE_BITS = sts_pkg::DEF_SINE_TABLE_BITS
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wr_en,
	input  wire logic [sts_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [sts_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [7:0]                       s_tdata,   // [0] tone_on
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic      [39:0]                      m_tdata,   // [31:0] sample_word, [34:32] byte_count
	output logic                                  m_tuser,   // [0] channel
	output logic                                  m_tlast
);
	import sts_pkg::*;

	cfg_t                 cfg_q;
	logic                 queue_full;
	logic                 queue_empty;
	logic                 push;
	logic                 pop;
	logic [SINE_TABLE_BITS:0] push_data;
	logic [SINE_TABLE_BITS:0] pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_increment <= RST_PHASE_INC;
			cfg_q.amplitude       <= RST_AMPLITUDE;
			cfg_q.sample_format   <= RST_FORMAT;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_PHASE_INC: cfg_q.phase_increment <= cfg_data;
				CFG_AMPLITUDE: cfg_q.amplitude       <= cfg_data[14:0];
				CFG_FORMAT:    cfg_q.sample_format   <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	sts_front #(
		.SINE_TABLE_BITS(SINE_TABLE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.cfg       (cfg_q),
		.queue_full(queue_full),
		.push      (push),
		.push_data (push_data)
	);

	sts_fifo #(
		.WIDTH(SINE_TABLE_BITS + 1)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.pop_data (pop_data),
		.full     (queue_full),
		.empty    (queue_empty)
	);

	sts_back #(
		.NUM_CHANNELS   (NUM_CHANNELS),
		.SINE_TABLE_BITS(SINE_TABLE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.queue_empty(queue_empty),
		.queue_data (pop_data),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

	`STS_ASSERT_NOW(a_short_word_zero_top, m_tvalid && (m_tdata[34:32] == 3'd2), m_tdata[31:16] == 16'd0, "int16 word has bits above its two bytes")

	`STS_ASSERT_NEXT(a_frame_continues, m_tvalid && m_tready && !m_tlast, m_tvalid, "channel words of a frame were not issued back to back")

	`STS_ASSERT_NOW(a_last_channel, m_tvalid && m_tlast, m_tuser == 1'((NUM_CHANNELS - 1) % 2), "last word of a frame carries the wrong channel")

endmodule

`default_nettype wire
